FILE: hw/rtl/g3d_pkg.sv
// shared types, constants and the 2^-(i/16) table for the gaussian point evaluator
`timescale 1ns / 1ps

package g3d_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_INV_VAR_LAT = 3'd3;
  localparam logic [2:0] REG_INV_VAR_AX = 3'd4;

  localparam int IV_WIDTH = 24;
  localparam logic [IV_WIDTH-1:0] IV_RESET = 24'd65536;

  // exponent argument limit is 2^ARG_BIT in the Q.32 domain
  localparam int ARG_BIT = 37;
  localparam logic [ARG_BIT:0] ARG_LIMIT = {1'b1, {ARG_BIT{1'b0}}};

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  // word handed from the distance/scale front end to the exponential unit
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic        over;
    logic [19:0] a16;
  } exp_req_t;

  function automatic logic [16:0] pow2_frac(input logic [3:0] idx);
    logic [16:0] val;
    case (idx)
      4'd0:    val = 17'd65536;
      4'd1:    val = 17'd62757;
      4'd2:    val = 17'd60097;
      4'd3:    val = 17'd57549;
      4'd4:    val = 17'd55109;
      4'd5:    val = 17'd52773;
      4'd6:    val = 17'd50535;
      4'd7:    val = 17'd48393;
      4'd8:    val = 17'd46341;
      4'd9:    val = 17'd44376;
      4'd10:   val = 17'd42495;
      4'd11:   val = 17'd40693;
      4'd12:   val = 17'd38968;
      4'd13:   val = 17'd37316;
      4'd14:   val = 17'd35734;
      default: val = 17'd34219;
    endcase
    return val;
  endfunction

endpackage

FILE: hw/rtl/gaussian_3d_point_eval_core.sv
// top level of the anisotropic 3d gaussian point evaluator
`timescale 1ns / 1ps

// Streams 3d points in and gives one gaussian value per point.
// Input channel: point_x/point_y/point_z (signed Q12.8) are taken at a rising
// edge with start high and busy low. busy is high only in the cycle after reset;
// from then on a new point can be taken in every cycle.
// Output channel: done is high for one cycle with gauss_value (unsigned
// Q0.OUT_WIDTH). The receiver cannot stall, so results are never held back.
// Pipeline: five front-end stages for offsets, squares, sums, variance scaling
// and argument, then five stages in the exponential unit. Throughput is one
// point per cycle, set by the fully pipelined multipliers in each stage.
// Configuration: cfg_wr_en/cfg_index/cfg_data write a register;
// index 0..2 center x/y/z, 3 lateral and 4 axial inverse variance (Q8.16).
// Other indexes are ignored. Write only while no point is in flight.
// Reset clears the pipeline valid bits, centers to 0 and inverse variances
// to 1.0.
module gaussian_3d_point_eval_core #(
  parameter int COORD_WIDTH = 20,
  parameter int OUT_WIDTH = 16,
  localparam int CFG_W = (COORD_WIDTH > g3d_pkg::IV_WIDTH) ? COORD_WIDTH : g3d_pkg::IV_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          done,
  output logic        [OUT_WIDTH-1:0]   gauss_value,
  input  logic                          cfg_wr_en,
  input  logic        [2:0]             cfg_index,
  input  logic        [CFG_W-1:0]       cfg_data
);

  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int SQX_W = (SQ_W > g3d_pkg::ARG_BIT + 1) ? SQ_W : g3d_pkg::ARG_BIT + 1;
  localparam int LATENCY = 10;
  localparam int AB = g3d_pkg::ARG_BIT;

  localparam logic [SQX_W-1:0] SQ_LIMIT = SQX_W'(g3d_pkg::ARG_LIMIT);
  localparam logic [AB+24-1:0] PROD_LIMIT = (AB+24)'(g3d_pkg::ARG_LIMIT);

  logic [COORD_WIDTH-1:0] center_x, center_y, center_z;
  logic [g3d_pkg::IV_WIDTH-1:0] inv_var_lateral, inv_var_axial;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      inv_var_lateral <= g3d_pkg::IV_RESET;
      inv_var_axial <= g3d_pkg::IV_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          g3d_pkg::REG_CENTER_X:    center_x <= cfg_data[COORD_WIDTH-1:0];
          g3d_pkg::REG_CENTER_Y:    center_y <= cfg_data[COORD_WIDTH-1:0];
          g3d_pkg::REG_CENTER_Z:    center_z <= cfg_data[COORD_WIDTH-1:0];
          g3d_pkg::REG_INV_VAR_LAT: inv_var_lateral <= cfg_data[g3d_pkg::IV_WIDTH-1:0];
          g3d_pkg::REG_INV_VAR_AX:  inv_var_axial <= cfg_data[g3d_pkg::IV_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  // stage 1: absolute offsets from the center
  logic [COORD_WIDTH:0] dx, dy, dz;
  logic [COORD_WIDTH:0] ndx, ndy, ndz;
  logic                   s1_v;
  logic [COORD_WIDTH-1:0] ad_x, ad_y, ad_z;

  always_comb begin
    dx = {point_x[COORD_WIDTH-1], point_x} - {center_x[COORD_WIDTH-1], center_x};
    dy = {point_y[COORD_WIDTH-1], point_y} - {center_y[COORD_WIDTH-1], center_y};
    dz = {point_z[COORD_WIDTH-1], point_z} - {center_z[COORD_WIDTH-1], center_z};
    ndx = ~dx + 1'b1;
    ndy = ~dy + 1'b1;
    ndz = ~dz + 1'b1;
  end

  // stage 2: clamped squares
  logic [SQX_W-1:0] sqx_x, sqx_y, sqx_z;
  logic             s2_v;
  logic [AB:0]      sq_x, sq_y, sq_z;

  always_comb begin
    sqx_x = SQX_W'(ad_x) * SQX_W'(ad_x);
    sqx_y = SQX_W'(ad_y) * SQX_W'(ad_y);
    sqx_z = SQX_W'(ad_z) * SQX_W'(ad_z);
  end

  // stage 3: lateral sum, split into in-range value and overflow flag
  logic [AB+1:0] lat_sum;
  logic          s3_v;
  logic          lat_big, ax_big;
  logic [AB-1:0] lat, ax;

  assign lat_sum = {1'b0, sq_x} + {1'b0, sq_y};

  // stage 4: scale by inverse variances, clamp to the argument limit
  logic [AB+24-1:0] prod_l, prod_a;
  logic [AB:0]      term_l_next, term_a_next;
  logic             s4_v;
  logic [AB:0]      term_l, term_a;

  always_comb begin
    prod_l = lat * inv_var_lateral;
    prod_a = ax * inv_var_axial;
    if (lat_big) begin
      term_l_next = (inv_var_lateral == '0) ? '0 : g3d_pkg::ARG_LIMIT;
    end else if (prod_l > PROD_LIMIT) begin
      term_l_next = g3d_pkg::ARG_LIMIT;
    end else begin
      term_l_next = prod_l[AB:0];
    end
    if (ax_big) begin
      term_a_next = (inv_var_axial == '0) ? '0 : g3d_pkg::ARG_LIMIT;
    end else if (prod_a > PROD_LIMIT) begin
      term_a_next = g3d_pkg::ARG_LIMIT;
    end else begin
      term_a_next = prod_a[AB:0];
    end
  end

  // stage 5: exponent argument and special-case flags
  logic [AB+1:0]     t_sum;
  g3d_pkg::exp_req_t req;

  assign t_sum = {1'b0, term_l} + {1'b0, term_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    ad_x <= dx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
    ad_y <= dy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
    ad_z <= dz[COORD_WIDTH] ? ndz[COORD_WIDTH-1:0] : dz[COORD_WIDTH-1:0];

    sq_x <= (sqx_x > SQ_LIMIT) ? g3d_pkg::ARG_LIMIT : sqx_x[AB:0];
    sq_y <= (sqx_y > SQ_LIMIT) ? g3d_pkg::ARG_LIMIT : sqx_y[AB:0];
    sq_z <= (sqx_z > SQ_LIMIT) ? g3d_pkg::ARG_LIMIT : sqx_z[AB:0];

    lat_big <= lat_sum[AB+1] | lat_sum[AB];
    lat <= lat_sum[AB-1:0];
    ax_big <= sq_z[AB];
    ax <= sq_z[AB-1:0];

    term_l <= term_l_next;
    term_a <= term_a_next;
  end

  always_ff @(posedge clk) begin
    req.zero <= (t_sum == '0);
    req.over <= t_sum[AB+1] | t_sum[AB];
    req.a16 <= t_sum[AB-1:17];
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= s4_v;
    end
  end

  g3d_exp2 #(
    .OUT_WIDTH(OUT_WIDTH)
  ) u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (done),
    .out_value (gauss_value)
  );

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted point produced no result word");

  a_no_spurious_word: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##LATENCY !done)
    else $error("result word without an accepted point");

endmodule

FILE: hw/rtl/g3d_exp2.sv
// pipelined e^-x exponential as 2^-(x*log2 e): range reduction, fraction table, quadratic correction
`timescale 1ns / 1ps

module g3d_exp2 #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  g3d_pkg::exp_req_t     req,
  output logic                  out_valid,
  output logic [OUT_WIDTH-1:0]  out_value
);

  localparam logic [24:0] MAXV = 25'((1 << OUT_WIDTH) - 1);
  localparam logic [5:0] SHIFT_BIAS = 6'(24 - OUT_WIDTH);
  localparam logic [36:0] LOG2E_Q16_EXT = 37'(g3d_pkg::LOG2E_Q16);

  // stage e1: base-2 exponent
  logic        e1_v, e1_zero, e1_large;
  logic [20:0] e1_u16;
  // stage e2: split into shift, table index and correction term
  logic        e2_v, e2_zero, e2_large;
  logic [4:0]  e2_n;
  logic [3:0]  e2_idx;
  logic [11:0] e2_t;
  // stage e3: correction factor
  logic        e3_v, e3_zero, e3_large;
  logic [4:0]  e3_n;
  logic [3:0]  e3_idx;
  logic [16:0] e3_c;
  // stage e4: mantissa
  logic        e4_v, e4_zero, e4_large;
  logic [4:0]  e4_n;
  logic [16:0] e4_m;

  logic [37:0] u_full;
  logic [28:0] t_full;
  logic [23:0] tt;
  logic [23:0] tt_rnd;
  logic [16:0] c_next;
  logic [34:0] m_full;
  logic [5:0]  shift;
  logic [5:0]  shift_m1;
  logic [24:0] v;
  logic [24:0] shifted;
  logic [25:0] rnd_sum;
  logic [24:0] res;

  always_comb begin
    u_full = 38'(req.a16 * LOG2E_Q16_EXT) + 38'd32768;
  end

  always_comb begin
    t_full = 29'(e1_u16[11:0]) * 29'(g3d_pkg::LN2_Q16) + 29'd32768;
    tt = 24'(e2_t) * 24'(e2_t);
    tt_rnd = tt + 24'd65536;
    c_next = 17'd65536 - 17'(e2_t) + 17'(tt_rnd[23:17]);
    m_full = 35'(g3d_pkg::pow2_frac(e3_idx)) * 35'(e3_c) + 35'd32768;
  end

  always_comb begin
    shift = {1'b0, e4_n} + SHIFT_BIAS;
    shift_m1 = shift - 6'd1;
    v = {e4_m, 8'b0};
    shifted = v >> shift_m1;
    rnd_sum = {1'b0, shifted} + 26'd1;
    if (shift == 6'd0) begin
      res = v;
    end else if (shift >= 6'd40) begin
      res = '0;
    end else begin
      res = rnd_sum[25:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      e1_v <= req.valid;
      e2_v <= e1_v;
      e3_v <= e2_v;
      e4_v <= e3_v;
      out_valid <= e4_v;
    end
  end

  always_ff @(posedge clk) begin
    e1_zero <= req.zero;
    e1_large <= req.over;
    e1_u16 <= u_full[36:16];

    e2_zero <= e1_zero;
    e2_large <= e1_large;
    e2_n <= e1_u16[20:16];
    e2_idx <= e1_u16[15:12];
    e2_t <= t_full[27:16];

    e3_zero <= e2_zero;
    e3_large <= e2_large;
    e3_n <= e2_n;
    e3_idx <= e2_idx;
    e3_c <= c_next;

    e4_zero <= e3_zero;
    e4_large <= e3_large;
    e4_n <= e3_n;
    e4_m <= m_full[32:16];

    if (e4_zero) begin
      out_value <= MAXV[OUT_WIDTH-1:0];
    end else if (e4_large) begin
      out_value <= '0;
    end else if (res > MAXV) begin
      out_value <= MAXV[OUT_WIDTH-1:0];
    end else begin
      out_value <= res[OUT_WIDTH-1:0];
    end
  end

  a_center_saturates: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.zero) |-> ##5 (out_valid && out_value == MAXV[OUT_WIDTH-1:0]))
    else $error("centered point did not give full scale");

  a_large_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.over && !req.zero) |-> ##5 (out_valid && out_value == '0))
    else $error("large argument did not give zero");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the 3d gaussian point evaluator core
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 20;
  localparam int OUT_W = 16;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_POINTS = 125;
  localparam longint unsigned ARG_CAP = 64'd1 << 37;
  localparam longint unsigned LOG2E_FX = 64'd94548;
  localparam longint unsigned LN2_FX = 64'd45426;
  localparam longint unsigned GAUSS_MAX = (64'd1 << OUT_W) - 64'd1;
  localparam logic [23:0] UNITY_Q16 = 24'd65536;
  localparam logic signed [CW-1:0] COORD_MAX = 20'sh7FFFF;
  localparam logic signed [CW-1:0] COORD_MIN = 20'sh80000;
  // indexes past the last register, writes there must be dropped
  localparam logic [2:0] CFG_IDX_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CFG_IDX_SPARE_LAST = 3'd7;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct {
    point_t               pt;
    logic [OUT_W-1:0]     value;
  } gauss_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic signed [CW-1:0] point_z = '0;
  logic done;
  logic [OUT_W-1:0] gauss_value;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = g3d_pkg::REG_CENTER_X;
  logic [23:0] cfg_data = '0;

  // shadow of the configuration registers
  logic signed [CW-1:0] ctr_x = '0;
  logic signed [CW-1:0] ctr_y = '0;
  logic signed [CW-1:0] ctr_z = '0;
  logic [23:0] ivar_lat = UNITY_Q16;
  logic [23:0] ivar_ax = UNITY_Q16;

  int unsigned exp2_frac_q16 [16] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219
  };

  point_t pending_points[$];
  gauss_expect_t expected_gauss[$];
  int gap_left = 0;
  bit no_gaps = 1'b0;
  int errors = 0;

  gaussian_3d_point_eval_core #(
    .COORD_WIDTH(CW),
    .OUT_WIDTH(OUT_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .done(done),
    .gauss_value(gauss_value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned clamped_sq(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] c);
    longint d;
    longint unsigned mag;
    longint unsigned sq;
    d = longint'(p) - longint'(c);
    mag = (d < 0) ? -d : d;
    sq = mag * mag;
    return (sq > ARG_CAP) ? ARG_CAP : sq;
  endfunction

  function automatic longint unsigned capped_term(input longint unsigned s,
                                                  input logic [23:0] iv);
    longint unsigned p;
    p = s * {40'd0, iv};
    return (p > ARG_CAP) ? ARG_CAP : p;
  endfunction

  function automatic logic [OUT_W-1:0] gauss_of_point(input point_t pt);
    longint unsigned t_sum, a16, u16, n, idx, r, tq, corr, mant, wide, sh, val;
    t_sum = capped_term(clamped_sq(pt.x, ctr_x) + clamped_sq(pt.y, ctr_y), ivar_lat)
          + capped_term(clamped_sq(pt.z, ctr_z), ivar_ax);
    if (t_sum == 0) begin
      val = GAUSS_MAX;
    end else if (t_sum >= ARG_CAP) begin
      val = 0;
    end else begin
      // exp(-a) = 2^-(a*log2 e), integer part shifts, fraction from table
      a16 = t_sum >> 17;
      u16 = (a16 * LOG2E_FX + 64'd32768) >> 16;
      n = u16 >> 16;
      idx = (u16 >> 12) & 64'd15;
      r = u16 & 64'hFFF;
      tq = (r * LN2_FX + 64'd32768) >> 16;
      corr = 64'd65536 - tq + ((tq * tq + 64'd65536) >> 17);
      mant = ({32'd0, exp2_frac_q16[idx[3:0]]} * corr + 64'd32768) >> 16;
      wide = mant << 8;
      sh = n + 64'd24 - OUT_W;
      if (sh >= 40) begin
        wide = 0;
      end else if (sh != 0) begin
        wide = (wide + (64'd1 << (sh - 1))) >> sh;
      end
      val = (wide > GAUSS_MAX) ? GAUSS_MAX : wide;
    end
    return val[OUT_W-1:0];
  endfunction

  function automatic logic signed [CW-1:0] near_coord(input logic signed [CW-1:0] c,
                                                      input int w);
    logic [CW-1:0] off;
    if (w == 0) return c;
    off = CW'($urandom() & ((32'd1 << w) - 1));
    off = off - (20'd1 << (w - 1));
    return c + off;
  endfunction

  function automatic logic [23:0] center_word();
    logic [23:0] w;
    w = 24'($urandom());
    case ($urandom_range(0, 3))
      0: w[CW-1:0] = COORD_MAX;
      1: w[CW-1:0] = COORD_MIN;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [23:0] ivar_word();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return UNITY_Q16;
      3: return 24'($urandom());
      default: return 24'($urandom() >> $urandom_range(0, 23));
    endcase
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      g3d_pkg::REG_CENTER_X: ctr_x = data[CW-1:0];
      g3d_pkg::REG_CENTER_Y: ctr_y = data[CW-1:0];
      g3d_pkg::REG_CENTER_Z: ctr_z = data[CW-1:0];
      g3d_pkg::REG_INV_VAR_LAT: ivar_lat = data;
      g3d_pkg::REG_INV_VAR_AX: ivar_ax = data;
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_points.size() != 0 || start || expected_gauss.size() != 0)
      @(negedge clk);
  endtask

  task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                           input logic signed [CW-1:0] z);
    point_t pt;
    pt.x = x;
    pt.y = y;
    pt.z = z;
    pending_points.push_back(pt);
  endtask

  // driver: presents queued words, draws an idle gap after each one
  always @(posedge clk) begin : driver
    point_t nxt;
    bit free;
    gauss_expect_t e;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      free = !start;
      if (start && !busy) begin
        e.pt.x = point_x;
        e.pt.y = point_y;
        e.pt.z = point_z;
        e.value = gauss_of_point(e.pt);
        expected_gauss.push_back(e);
        free = 1'b1;
      end
      if (free) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_points.size() != 0) begin
          nxt = pending_points.pop_front();
          point_x <= nxt.x;
          point_y <= nxt.y;
          point_z <= nxt.z;
          start <= 1'b1;
          gap_left <= no_gaps ? 0 : $urandom_range(0, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    gauss_expect_t e;
    if (!rst && done) begin
      if (expected_gauss.size() == 0) begin
        $display("%0t unexpected word: expected none actual gauss_value %0d",
                 $time, gauss_value);
        errors++;
      end else begin
        e = expected_gauss.pop_front();
        if (gauss_value !== e.value) begin
          $display("%0t gauss_value mismatch for point (%0d, %0d, %0d): expected %0d actual %0d",
                   $time, e.pt.x, e.pt.y, e.pt.z, e.value, gauss_value);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int wmax;
    logic signed [CW-1:0] c [3];
    logic signed [CW-1:0] q [3];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: exact center, far corners, a few small offsets
    add_point(0, 0, 0);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX);
    add_point(COORD_MIN, COORD_MIN, COORD_MIN);
    add_point(COORD_MAX, COORD_MIN, 0);
    add_point(1, 0, 0);
    add_point(0, -1, 0);
    add_point(0, 0, 256);
    add_point(256, 256, 0);
    add_point(1450, 0, -1450);
    wait_idle();

    // x/y centers at the extremes, z at 256, junk above bit 19 on x and z, lateral weight zero
    cfg_write(g3d_pkg::REG_CENTER_X, 24'hF7FFFF);
    cfg_write(g3d_pkg::REG_CENTER_Y, 24'h080000);
    cfg_write(g3d_pkg::REG_CENTER_Z, 24'hA00100);
    cfg_write(g3d_pkg::REG_INV_VAR_LAT, 24'd0);
    cfg_write(g3d_pkg::REG_INV_VAR_AX, UNITY_Q16);
    cfg_write(CFG_IDX_SPARE_FIRST, 24'hFFFFFF);
    cfg_write(CFG_IDX_SPARE_LAST, 24'h000000);
    cfg_close();
    add_point(COORD_MAX, COORD_MIN, 20'sh00100);
    add_point(COORD_MIN, COORD_MAX, 20'sh00100);
    add_point(0, 0, 20'sh00101);
    add_point(0, 0, 20'sh00100 + 20'sd1450);
    add_point(0, 0, COORD_MIN);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX);
    wait_idle();

    // largest weights: one lsb off center already costs something
    cfg_write(g3d_pkg::REG_CENTER_X, 24'd0);
    cfg_write(g3d_pkg::REG_CENTER_Y, 24'd0);
    cfg_write(g3d_pkg::REG_CENTER_Z, 24'd0);
    cfg_write(g3d_pkg::REG_INV_VAR_LAT, 24'hFFFFFF);
    cfg_write(g3d_pkg::REG_INV_VAR_AX, 24'hFFFFFF);
    cfg_close();
    add_point(1, 0, 0);
    add_point(0, 0, 1);
    add_point(1, 1, 1);
    add_point(16, 0, 0);
    add_point(0, 0, -16);
    add_point(100, 0, 0);
    add_point(COORD_MAX, 0, 0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 3) != 0) cfg_write(g3d_pkg::REG_CENTER_X, center_word());
      if ($urandom_range(0, 3) != 0) cfg_write(g3d_pkg::REG_CENTER_Y, center_word());
      if ($urandom_range(0, 3) != 0) cfg_write(g3d_pkg::REG_CENTER_Z, center_word());
      if ($urandom_range(0, 3) != 0) cfg_write(g3d_pkg::REG_INV_VAR_LAT, ivar_word());
      if ($urandom_range(0, 3) != 0) cfg_write(g3d_pkg::REG_INV_VAR_AX, ivar_word());
      if ($urandom_range(0, 3) == 0)
        cfg_write(3'($urandom_range(CFG_IDX_SPARE_FIRST, CFG_IDX_SPARE_LAST)),
                  24'($urandom()));
      cfg_close();
      no_gaps = ($urandom_range(0, 3) == 0);
      c[0] = ctr_x;
      c[1] = ctr_y;
      c[2] = ctr_z;
      for (int k = 0; k < PHASE_POINTS; k++) begin
        case ($urandom_range(0, 9))
          0: q = c;
          1: begin
            for (int j = 0; j < 3; j++) q[j] = CW'($urandom());
          end
          2: begin
            for (int j = 0; j < 3; j++)
              case ($urandom_range(0, 2))
                0: q[j] = COORD_MAX;
                1: q[j] = COORD_MIN;
                default: q[j] = c[j];
              endcase
          end
          default: begin
            // most points land near the center so the exponential is exercised
            wmax = $urandom_range(0, CW);
            for (int j = 0; j < 3; j++) q[j] = near_coord(c[j], $urandom_range(0, wmax));
          end
        endcase
        add_point(q[0], q[1], q[2]);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
